### rtl/fuzzy_two_input_inference_assert.svh
// assertion macros used by the port-level checker
`ifndef FUZZY_TWO_INPUT_INFERENCE_ASSERT_SVH
`define FUZZY_TWO_INPUT_INFERENCE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define FTI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fuzzy inference implication check failed");

// condition that must never be seen outside reset
`define FTI_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("fuzzy inference forbidden condition seen");

`endif

### rtl/fti_pkg.sv
// shared types, constants and membership classify functions
package fti_pkg;

  localparam int DEGREE_FRAC_BITS_DEF = 15;
  localparam int XW      = 16;
  localparam int CFG_AW  = 3;
  localparam int NUM_DEG = 6;
  localparam int NUM_RULES = 9;
  localparam int SCORE_W = 7;

  // degree lanes: distance far, mid, near; energy low, mid, high
  localparam int DEG_FAR  = 0;
  localparam int DEG_DMID = 1;
  localparam int DEG_NEAR = 2;
  localparam int DEG_LOW  = 3;
  localparam int DEG_EMID = 4;
  localparam int DEG_HIGH = 5;

  typedef enum logic [CFG_AW-1:0] {
    CFG_DIST_MID_START   = 3'd0,
    CFG_DIST_NEAR_END    = 3'd1,
    CFG_DIST_MID_PEAK    = 3'd2,
    CFG_DIST_MID_END     = 3'd3,
    CFG_DIST_FAR_FULL    = 3'd4,
    CFG_ENERGY_LOW_END   = 3'd5,
    CFG_ENERGY_MID_PEAK  = 3'd6,
    CFG_ENERGY_HIGH_FULL = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [XW-1:0] dist_mid_start;
    logic [XW-1:0] dist_near_end;
    logic [XW-1:0] dist_mid_peak;
    logic [XW-1:0] dist_mid_end;
    logic [XW-1:0] dist_far_full;
    logic [XW-1:0] energy_low_end;
    logic [XW-1:0] energy_mid_peak;
    logic [XW-1:0] energy_high_full;
  } cfg_t;

  // a degree as numerator over denominator, numerator never above denominator
  typedef struct packed {
    logic [XW-1:0] num;
    logic [XW-1:0] den;
  } frac_t;

  typedef frac_t [NUM_DEG-1:0] cls_t;

  localparam logic [SCORE_W-1:0] CENTRE [NUM_RULES] = '{
    7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90
  };

  localparam frac_t FRAC_ZERO = '{num: 16'd0, den: 16'd1};
  localparam frac_t FRAC_ONE  = '{num: 16'd1, den: 16'd1};

  function automatic frac_t cls_falling(logic [XW-1:0] x, logic [XW-1:0] c,
                                        logic [XW-1:0] d);
    frac_t r;
    if (x <= c) begin
      r = FRAC_ONE;
    end else if (x <= d) begin
      r.num = d - x;
      r.den = d - c;
    end else begin
      r = FRAC_ZERO;
    end
    return r;
  endfunction

  function automatic frac_t cls_rising(logic [XW-1:0] x, logic [XW-1:0] a,
                                       logic [XW-1:0] b);
    frac_t r;
    if (x < a) begin
      r = FRAC_ZERO;
    end else if (x < b) begin
      r.num = x - a;
      r.den = b - a;
    end else begin
      r = FRAC_ONE;
    end
    return r;
  endfunction

  function automatic frac_t cls_triangle(logic [XW-1:0] x, logic [XW-1:0] e,
                                         logic [XW-1:0] f, logic [XW-1:0] g);
    frac_t r;
    if (x <= e) begin
      r = FRAC_ZERO;
    end else if (x <= f) begin
      r.num = x - e;
      r.den = f - e;
    end else if (x <= g) begin
      r.num = g - x;
      r.den = g - f;
    end else begin
      r = FRAC_ZERO;
    end
    return r;
  endfunction

endpackage

### rtl/fti_queue.sv
// two-entry queue between the classify front and the compute back
module fti_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fti_pkg::cls_t   push_data,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output fti_pkg::cls_t   head
);
  import fti_pkg::*;

  cls_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/fti_front.sv
// front end: takes transactions and classifies each one into six fractions
module fti_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [15:0]            distance,
  input  logic [15:0]            energy,
  input  fti_pkg::cfg_t          cfg,
  input  logic                   q_full,
  output logic                   busy,
  output logic                   push,
  output fti_pkg::cls_t          push_data
);
  import fti_pkg::*;

  logic hold_valid;
  cls_t hold_cls;
  cls_t cls_next;
  logic accept;

  assign busy      = hold_valid && q_full;
  assign accept    = start && !busy;
  assign push      = hold_valid;
  assign push_data = hold_cls;

  always_comb begin
    cls_next[DEG_FAR]  = cls_rising(distance, cfg.dist_mid_peak, cfg.dist_far_full);
    cls_next[DEG_DMID] = cls_triangle(distance, cfg.dist_mid_start, cfg.dist_mid_peak,
                                      cfg.dist_mid_end);
    cls_next[DEG_NEAR] = cls_falling(distance, cfg.dist_near_end, cfg.dist_mid_peak);
    cls_next[DEG_LOW]  = cls_falling(energy, cfg.energy_low_end, cfg.energy_mid_peak);
    cls_next[DEG_EMID] = cls_triangle(energy, cfg.energy_low_end, cfg.energy_mid_peak,
                                      cfg.energy_high_full);
    cls_next[DEG_HIGH] = cls_rising(energy, cfg.energy_mid_peak, cfg.energy_high_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (!q_full) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_cls <= cls_next;
    end
  end

endmodule

### rtl/fti_div.sv
// pipelined restoring divider: (num << F) / den, one quotient bit per stage
module fti_div #(
  parameter int F = fti_pkg::DEGREE_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  fti_pkg::frac_t  din,
  output logic [F:0]      quo
);
  import fti_pkg::*;

  localparam int QW = F + 1;

  logic [XW-1:0] rem   [QW];
  logic [XW-1:0] dvs   [QW];
  logic [QW-1:0] qp    [QW];
  logic [XW:0]   trial [QW];
  logic [XW-1:0] dvin  [QW];
  logic [XW:0]   diff  [QW];
  logic          ge    [QW];

  always_comb begin
    trial[0] = {1'b0, din.num};
    dvin[0]  = din.den;
    for (int s = 1; s < QW; s++) begin
      trial[s] = {rem[s-1], 1'b0};
      dvin[s]  = dvs[s-1];
    end
    for (int s = 0; s < QW; s++) begin
      ge[s]   = trial[s] >= {1'b0, dvin[s]};
      diff[s] = trial[s] - {1'b0, dvin[s]};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QW; s++) begin
      rem[s] <= ge[s] ? diff[s][XW-1:0] : trial[s][XW-1:0];
      dvs[s] <= dvin[s];
    end
    qp[0] <= {{(QW-1){1'b0}}, ge[0]};
    for (int s = 1; s < QW; s++) begin
      qp[s] <= {qp[s-1][QW-2:0], ge[s]};
    end
  end

  assign quo = qp[QW-1];

endmodule

### rtl/fti_back.sv
// back end: degree dividers, rule minimums, weighted sums and score division
module fti_back #(
  parameter int F = fti_pkg::DEGREE_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  fti_pkg::cls_t   in_cls,
  output logic            done,
  output logic [6:0]      score,
  output logic [8:0]      rules_fired,
  output logic            no_rule
);
  import fti_pkg::*;

  localparam int DW   = F + 1;
  localparam int DENW = DW + 4;
  localparam int NW   = DW + 11;
  localparam int PW   = DW + 7;
  localparam int RNW  = DW + 9;
  localparam int RDW  = DW + 2;

  logic [DW-1:0] deg [NUM_DEG];
  logic [DW-1:0] dvld;

  for (genvar g = 0; g < NUM_DEG; g++) begin : g_lane
    fti_div #(.F(F)) u_div (
      .clk (clk),
      .din (in_cls[g]),
      .quo (deg[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld <= '0;
    end else begin
      dvld <= {dvld[DW-2:0], in_valid};
    end
  end

  // rule weights
  logic                 va;
  logic [DW-1:0]        wa [NUM_RULES];
  logic [NUM_RULES-1:0] ma;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        wa[j*3+i] <= (deg[i] <= deg[DEG_LOW+j]) ? deg[i] : deg[DEG_LOW+j];
        ma[j*3+i] <= (deg[i] != '0) && (deg[DEG_LOW+j] != '0);
      end
    end
  end

  // row sums
  logic           vb;
  logic [RNW-1:0] rnum [3];
  logic [RDW-1:0] rden [3];
  logic [NUM_RULES-1:0] mb;
  logic [PW-1:0]  prod [NUM_RULES];

  always_comb begin
    for (int k = 0; k < NUM_RULES; k++) begin
      prod[k] = PW'(wa[k]) * PW'(CENTRE[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      rnum[j] <= RNW'(prod[j*3]) + RNW'(prod[j*3+1]) + RNW'(prod[j*3+2]);
      rden[j] <= RDW'(wa[j*3]) + RDW'(wa[j*3+1]) + RDW'(wa[j*3+2]);
    end
    mb <= ma;
  end

  // totals
  logic            vc;
  logic [NW-1:0]   numc;
  logic [DENW-1:0] denc;
  logic [NUM_RULES-1:0] mc;

  always_ff @(posedge clk) begin
    numc <= NW'(rnum[0]) + NW'(rnum[1]) + NW'(rnum[2]);
    denc <= DENW'(rden[0]) + DENW'(rden[1]) + DENW'(rden[2]);
    mc   <= mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= dvld[DW-1];
      vb <= va;
      vc <= vb;
    end
  end

  // score division, quotient bit six first
  logic [NW-1:0]        srem [SCORE_W];
  logic [NW-1:0]        sden [SCORE_W];
  logic [SCORE_W-1:0]   squo [SCORE_W];
  logic [NUM_RULES-1:0] smask [SCORE_W];
  logic [SCORE_W-1:0]   sv;
  logic [NW-1:0]        rin  [SCORE_W];
  logic [NW-1:0]        din  [SCORE_W];
  logic [SCORE_W-1:0]   qin  [SCORE_W];
  logic [NUM_RULES-1:0] min_ [SCORE_W];
  logic [NW-1:0]        shd  [SCORE_W];
  logic                 sge  [SCORE_W];

  always_comb begin
    rin[0]  = numc;
    din[0]  = NW'(denc);
    qin[0]  = '0;
    min_[0] = mc;
    for (int s = 1; s < SCORE_W; s++) begin
      rin[s]  = srem[s-1];
      din[s]  = sden[s-1];
      qin[s]  = squo[s-1];
      min_[s] = smask[s-1];
    end
    for (int s = 0; s < SCORE_W; s++) begin
      shd[s] = din[s] << (SCORE_W - 1 - s);
      sge[s] = rin[s] >= shd[s];
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < SCORE_W; s++) begin
      srem[s]  <= sge[s] ? (rin[s] - shd[s]) : rin[s];
      sden[s]  <= din[s];
      squo[s]  <= {qin[s][SCORE_W-2:0], sge[s]};
      smask[s] <= min_[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else begin
      sv <= {sv[SCORE_W-2:0], vc};
    end
  end

  assign done        = sv[SCORE_W-1];
  assign rules_fired = smask[SCORE_W-1];
  assign no_rule     = (smask[SCORE_W-1] == '0);
  assign score       = no_rule ? '0 : squo[SCORE_W-1];

endmodule

### rtl/fuzzy_two_input_inference.sv
// top level of the two-input fuzzy inference block
//
// input channel: a transaction (distance Q8.8, energy Q4.12) is taken at a
// rising edge with start high and busy low. busy stays low in normal use, so
// one transaction can be taken every cycle.
// result channel: done is high for exactly one cycle with score, rules_fired
// and no_rule; the receiver cannot stall, nothing is held back.
// configuration: cfg_wr with cfg_addr and cfg_wdata writes one breakpoint
// register in that cycle; write only while no transaction is in flight.
// path: a taken transaction passes the front register and queue, the
// degree divider pipeline (one quotient bit per stage), the rule, row and
// total stages, and then the seven-stage score divider.
// throughput: one transaction per cycle while busy is low, every stage is fully pipelined.
// reset (rst, synchronous): breakpoints return to their defaults, the queue
// empties and all in-flight transactions are dropped.
module fuzzy_two_input_inference #(
  parameter int DEGREE_FRAC_BITS = fti_pkg::DEGREE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] distance,
  input  logic [15:0] energy,
  output logic        done,
  output logic [6:0]  score,
  output logic [8:0]  rules_fired,
  output logic        no_rule,
  input  logic        cfg_wr,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import fti_pkg::*;

  cfg_t cfg;
  logic q_full;
  logic q_empty;
  logic f_push;
  cls_t f_data;
  cls_t q_head;

  // breakpoint registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dist_mid_start   <= 16'd0;
      cfg.dist_near_end    <= 16'd128;
      cfg.dist_mid_peak    <= 16'd461;
      cfg.dist_mid_end     <= 16'd922;
      cfg.dist_far_full    <= 16'd1050;
      cfg.energy_low_end   <= 16'd410;
      cfg.energy_mid_peak  <= 16'd2048;
      cfg.energy_high_full <= 16'd3686;
    end else if (cfg_wr) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_DIST_MID_START:   cfg.dist_mid_start   <= cfg_wdata;
        CFG_DIST_NEAR_END:    cfg.dist_near_end    <= cfg_wdata;
        CFG_DIST_MID_PEAK:    cfg.dist_mid_peak    <= cfg_wdata;
        CFG_DIST_MID_END:     cfg.dist_mid_end     <= cfg_wdata;
        CFG_DIST_FAR_FULL:    cfg.dist_far_full    <= cfg_wdata;
        CFG_ENERGY_LOW_END:   cfg.energy_low_end   <= cfg_wdata;
        CFG_ENERGY_MID_PEAK:  cfg.energy_mid_peak  <= cfg_wdata;
        CFG_ENERGY_HIGH_FULL: cfg.energy_high_full <= cfg_wdata;
        default:              cfg <= cfg;
      endcase
    end
  end

  // front: register the classified fractions of each transaction
  fti_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .distance  (distance),
    .energy    (energy),
    .cfg       (cfg),
    .q_full    (q_full),
    .busy      (busy),
    .push      (f_push),
    .push_data (f_data)
  );

  // short queue, the back end drains it whenever it holds an entry
  fti_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data (f_data),
    .pop       (!q_empty),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  // back: dividers, rules and weighted average
  fti_back #(.F(DEGREE_FRAC_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (!q_empty),
    .in_cls      (q_head),
    .done        (done),
    .score       (score),
    .rules_fired (rules_fired),
    .no_rule     (no_rule)
  );

endmodule

### rtl/fti_checker.sv
// port-level checker for the fuzzy inference block and its bind
`include "fuzzy_two_input_inference_assert.svh"

module fti_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [6:0] score,
  input logic [8:0] rules_fired,
  input logic       no_rule
);

  `FTI_ASSERT_IMPL(a_flag_matches_mask, done, no_rule == (rules_fired == 9'd0))
  `FTI_ASSERT_IMPL(a_empty_scores_zero, done && no_rule, score == 7'd0)
  `FTI_ASSERT_IMPL(a_score_in_range, done, score <= 7'd90)
  `FTI_ASSERT_NEVER(a_front_never_blocks, busy && start)

endmodule

bind fuzzy_two_input_inference fti_checker u_fti_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .score       (score),
  .rules_fired (rules_fired),
  .no_rule     (no_rule)
);

### tb/sv/fuzzy_two_input_inference_checker.sv
// scoreboard: predicts each score transaction and compares it with the block output
module fuzzy_two_input_inference_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] distance,
  input  logic [15:0] energy,
  input  logic        done,
  input  logic [6:0]  score,
  input  logic [8:0]  rules_fired,
  input  logic        no_rule,
  input  logic        cfg_wr,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);
  import fti_pkg::*;

  localparam int FB = 15;

  typedef struct packed {
    logic [6:0] score;
    logic [8:0] rules_fired;
    logic       no_rule;
  } verdict_t;

  cfg_t       bp;
  verdict_t   verdict_q[$];

  function automatic longint unsigned ratio(longint unsigned n, longint unsigned d);
    return (n << FB) / d;
  endfunction

  function automatic longint unsigned falling_deg(longint unsigned x, longint unsigned c,
                                                  longint unsigned d);
    if (x <= c) return 64'd1 << FB;
    if (x <= d) return ratio(d - x, d - c);
    return 0;
  endfunction

  function automatic longint unsigned rising_deg(longint unsigned x, longint unsigned a,
                                                 longint unsigned b);
    if (x < a) return 0;
    if (x < b) return ratio(x - a, b - a);
    return 64'd1 << FB;
  endfunction

  function automatic longint unsigned tri_deg(longint unsigned x, longint unsigned e,
                                              longint unsigned f, longint unsigned g);
    if (x <= e) return 0;
    if (x <= f) return ratio(x - e, f - e);
    if (x <= g) return ratio(g - x, g - f);
    return 0;
  endfunction

  function automatic verdict_t infer_score(logic [15:0] d, logic [15:0] n, cfg_t c);
    longint unsigned dg[3];
    longint unsigned eg[3];
    longint unsigned w, num, den;
    verdict_t v;
    num = 0;
    den = 0;
    v = '0;
    dg[0] = rising_deg(d, c.dist_mid_peak, c.dist_far_full);
    dg[1] = tri_deg(d, c.dist_mid_start, c.dist_mid_peak, c.dist_mid_end);
    dg[2] = falling_deg(d, c.dist_near_end, c.dist_mid_peak);
    eg[0] = falling_deg(n, c.energy_low_end, c.energy_mid_peak);
    eg[1] = tri_deg(n, c.energy_low_end, c.energy_mid_peak, c.energy_high_full);
    eg[2] = rising_deg(n, c.energy_mid_peak, c.energy_high_full);
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        w = (dg[i] <= eg[j]) ? dg[i] : eg[j];
        if (w != 0) begin
          v.rules_fired[j*3+i] = 1'b1;
          num += w * (10 * (j * 3 + i + 1));
          den += w;
        end
      end
    end
    v.no_rule = (den == 0);
    v.score = (den != 0) ? 7'(num / den) : 7'd0;
    return v;
  endfunction

  assign pending = verdict_q.size();

  always @(posedge clk) begin
    verdict_t got, want;
    if (rst) begin
      bp <= '{16'd0, 16'd128, 16'd461, 16'd922, 16'd1050, 16'd410, 16'd2048, 16'd3686};
      verdict_q.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (done) begin
        got = '{score, rules_fired, no_rule};
        results_seen <= results_seen + 1;
        if (verdict_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result score=%0d mask=%h", score, rules_fired);
          fail_count <= fail_count + 1;
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: exp score=%0d mask=%h none=%b got score=%0d mask=%h none=%b",
                       want.score, want.rules_fired, want.no_rule,
                       got.score, got.rules_fired, got.no_rule);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) verdict_q.push_back(infer_score(distance, energy, bp));
      if (cfg_wr) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_DIST_MID_START:   bp.dist_mid_start   <= cfg_wdata;
          CFG_DIST_NEAR_END:    bp.dist_near_end    <= cfg_wdata;
          CFG_DIST_MID_PEAK:    bp.dist_mid_peak    <= cfg_wdata;
          CFG_DIST_MID_END:     bp.dist_mid_end     <= cfg_wdata;
          CFG_DIST_FAR_FULL:    bp.dist_far_full    <= cfg_wdata;
          CFG_ENERGY_LOW_END:   bp.energy_low_end   <= cfg_wdata;
          CFG_ENERGY_MID_PEAK:  bp.energy_mid_peak  <= cfg_wdata;
          CFG_ENERGY_HIGH_FULL: bp.energy_high_full <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end
endmodule

### tb/sv/tb.sv
// testbench top: clock, reset, stimulus phases and the final verdict
module tb;
  import fti_pkg::*;

  localparam int LATENCY = 28;
  localparam longint CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] distance = '0;
  logic [15:0] energy = '0;
  logic        done;
  logic [6:0]  score;
  logic [8:0]  rules_fired;
  logic        no_rule;
  logic        cfg_wr = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  int          fail_count, pending, results_seen;
  longint      cycles = 0;
  int          idle_pct = 0;
  int          sent = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  fuzzy_two_input_inference u_top (.*);

  fuzzy_two_input_inference_checker u_chk (.*);

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fuzzy_two_input_inference regression: fail");
      $finish;
    end
  end

  // one transaction, with an optional random gap before it
  task automatic send_item(input logic [15:0] d, input logic [15:0] n);
    while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    distance <= d;
    energy <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // let the pipeline empty before any register write
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // one register write; the caller drops cfg_wr after the last one
  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_wr <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // full breakpoint set, indexes in order
  task automatic load_set(input logic [15:0] v [8]);
    for (int i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), v[i]);
    cfg_wr <= 1'b0;
    @(posedge clk);
  endtask

  // values clustered around breakpoints so every branch is reached
  function automatic logic [15:0] near_bp(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] c);
    logic [15:0] base;
    case ($urandom_range(3, 0))
      0: base = a;
      1: base = b;
      2: base = c;
      default: return 16'($urandom);
    endcase
    return base + 16'($urandom_range(8, 0)) - 16'd4;
  endfunction

  task automatic random_burst(input int count, input logic [15:0] v [8]);
    for (int i = 0; i < count; i++)
      send_item(near_bp(v[1], v[2], v[4]), near_bp(v[5], v[6], v[7]));
  endtask

  initial begin
    logic [15:0] dflt [8];
    logic [15:0] cur [8];
    dflt = '{16'd0, 16'd128, 16'd461, 16'd922, 16'd1050, 16'd410, 16'd2048, 16'd3686};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes and the breakpoints at reset values
    send_item(16'h0000, 16'h0000);
    send_item(16'hffff, 16'hffff);
    send_item(16'h0000, 16'hffff);
    send_item(16'hffff, 16'h0000);
    send_item(16'd128, 16'd410);
    send_item(16'd129, 16'd411);
    send_item(16'd461, 16'd2048);
    send_item(16'd462, 16'd2049);
    send_item(16'd922, 16'd3686);
    send_item(16'd923, 16'd3687);
    send_item(16'd1049, 16'd3685);
    send_item(16'd1050, 16'd2047);
    send_item(16'h5555, 16'haaaa);
    send_item(16'haaaa, 16'h5555);
    drain();

    // all breakpoints zero: degenerate spans, every comparison collapses
    cur = '{default: 16'd0};
    load_set(cur);
    send_item(16'd0, 16'd0);
    send_item(16'd1, 16'd1);
    send_item(16'hffff, 16'd0);
    drain();

    // all at maximum
    cur = '{default: 16'hffff};
    load_set(cur);
    send_item(16'hfffe, 16'hffff);
    send_item(16'hffff, 16'hfffe);
    send_item(16'd0, 16'd0);
    drain();

    // misordered breakpoints, and one where no rule can fire
    cur = '{16'd900, 16'd800, 16'd100, 16'd50, 16'd20, 16'd3000, 16'd200, 16'd100};
    load_set(cur);
    send_item(16'd500, 16'd1000);
    send_item(16'd60, 16'd150);
    drain();
    cur = '{16'd1000, 16'd0, 16'd500, 16'd2000, 16'd2000, 16'd0, 16'd0, 16'd0};
    load_set(cur);
    send_item(16'd500, 16'd5);  // every distance degree is zero at the peak
    drain();

    // random phases: wide and tight breakpoint sets under several idle rates
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) cur = dflt;
      else if (ph == 7) cur = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd1, 16'd2, 16'd3};
      else begin
        for (int i = 0; i < 8; i++) cur[i] = 16'($urandom);
        if (ph % 2 == 0) cur.sort();
      end
      load_set(cur);
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 87;
        default: idle_pct = 21;
      endcase
      random_burst(170, cur);
      idle_pct = 0;
      drain();
    end

    $display("covered %0d transactions, %0d results, over 13 breakpoint sets", sent,
             results_seen);
    $display("random phases swept sender idling of 0, 21 and 87 percent");
    if (fail_count == 0 && pending == 0) begin
      $display("fuzzy_two_input_inference regression: pass");
    end else begin
      $display("fuzzy_two_input_inference regression: fail");
    end
    $finish;
  end
endmodule
